// File: src/ppe_pkg.sv
// shared constants and types for the particle pool engine
`timescale 1ns / 1ps
package ppe_pkg;
  localparam int PoolSize  = 1024;
  localparam int SlotW     = 10;
  localparam int CountW    = 11;
  localparam logic [31:0] RotStepQ32 = 32'd42949673;

  typedef enum logic [1:0] {
    CMD_EMIT = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic              latch;      // capture the command beat
    logic              emit_wr;    // write emitted particle
    logic              rd_en;      // issue a sweep read
    logic [SlotW-1:0]  rd_addr;
    logic              upd_wr;     // write back updated slot
    logic              clr_wr;     // clear a slot after reset
    logic [SlotW-1:0]  wr_addr;
    logic              calc;       // register arithmetic stage
    logic              report;     // drive the result beat
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]        cmd;
  } sts_t;

  function automatic logic [31:0] sat_add(input logic signed [48:0] v);
    if (v > 49'sd2147483647) sat_add = 32'h7fffffff;
    else if (v < -49'sd2147483648) sat_add = 32'h80000000;
    else sat_add = v[31:0];
  endfunction
endpackage

// File: src/ppe_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
module ppe_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/ppe_ctrl.sv
// sequencer for emit, read and the tick sweep
`timescale 1ns / 1ps
module ppe_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  ppe_pkg::sts_t           sts,
  output ppe_pkg::ctl_t           ctl,
  output logic                    busy
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMD  = 6'b000010,
    S_RDW  = 6'b000100,
    S_TICK = 6'b001000,
    S_DONE = 6'b010000,
    S_CLR  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  // sweep: rd issued at cnt, calc at cnt-1, write at cnt-2
  logic [ppe_pkg::SlotW:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  logic [ppe_pkg::SlotW:0] wr_idx;
  assign wr_idx = cnt_r - (ppe_pkg::SlotW+1)'(2);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    busy      = (state_r != S_IDLE);
    ctl.rd_addr = cnt_r[ppe_pkg::SlotW-1:0];
    ctl.wr_addr = wr_idx[ppe_pkg::SlotW-1:0];
    unique case (state_r)
      S_CLR: begin
        ctl.clr_wr  = 1'b1;
        ctl.wr_addr = cnt_r[ppe_pkg::SlotW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ppe_pkg::SlotW+1)'(ppe_pkg::PoolSize - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        unique case (ppe_pkg::cmd_t'(sts.cmd))
          ppe_pkg::CMD_EMIT: begin
            ctl.emit_wr = 1'b1;
            state_nxt = S_DONE;
          end
          ppe_pkg::CMD_TICK: begin
            cnt_nxt = '0;
            state_nxt = S_TICK;
          end
          ppe_pkg::CMD_READ: state_nxt = S_RDW;
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDW: state_nxt = S_DONE;
      S_TICK: begin
        ctl.rd_en   = cnt_r < (ppe_pkg::SlotW+1)'(ppe_pkg::PoolSize);
        ctl.calc    = cnt_r >= (ppe_pkg::SlotW+1)'(1) &&
                      cnt_r < (ppe_pkg::SlotW+1)'(ppe_pkg::PoolSize + 1);
        ctl.upd_wr  = cnt_r >= (ppe_pkg::SlotW+1)'(2);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ppe_pkg::SlotW+1)'(ppe_pkg::PoolSize + 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.report = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: src/ppe_dp.sv
// particle memory, update arithmetic, flags and count
`timescale 1ns / 1ps
module ppe_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ppe_pkg::ctl_t            ctl,
  output ppe_pkg::sts_t            sts,
  input  logic [1:0]                in_command,
  input  logic [ppe_pkg::SlotW-1:0] in_slot_index,
  input  logic signed [31:0]        in_pos_x, in_pos_y, in_pos_z,
  input  logic signed [31:0]        in_vel_x, in_vel_y, in_vel_z,
  input  logic [30:0]               in_life_time,
  input  logic [30:0]               in_delta_time,
  output logic                      out_valid,
  output logic [ppe_pkg::SlotW-1:0] out_slot_out,
  output logic                      out_slot_active,
  output logic signed [31:0]        out_x, out_y, out_z,
  output logic [31:0]               out_rotation,
  output logic signed [31:0]        out_life,
  output logic [ppe_pkg::CountW-1:0] out_active_count
);
  localparam int W = ppe_pkg::SlotW;
  logic [1:0]   cmd_r;
  logic [W-1:0] idx_r;
  logic [30:0]  dt_r;
  logic [31:0]  rstep_r;
  logic [63:0]  rprod;
  logic [W-1:0] next_slot_r, next_slot_nxt;
  logic [ppe_pkg::CountW-1:0] cnt_r, cnt_nxt;

  // memory word: active px py pz vx vy vz life rot
  logic [256:0] wdata, rdata, emit_word, emit_word_r, upd_word;
  logic         we;
  logic [W-1:0] waddr, raddr;

  assign sts.cmd = cmd_r;
  assign rprod = {33'd0, in_delta_time} * {32'd0, ppe_pkg::RotStepQ32};
  assign emit_word = {1'b1, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z,
                      1'b0, in_life_time, 32'd0};

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r       <= in_command;
      idx_r       <= in_slot_index;
      dt_r        <= in_delta_time;
      rstep_r     <= rprod[63:32];
      emit_word_r <= emit_word;
    end
  end

  assign we    = ctl.emit_wr || ctl.upd_wr || ctl.clr_wr;
  assign waddr = ctl.emit_wr ? next_slot_r : ctl.wr_addr;
  assign wdata = ctl.emit_wr ? emit_word_r : (ctl.clr_wr ? '0 : upd_word);

  // emit looks up the old flag of its slot, read looks up the slot asked for
  always_comb begin
    priority if (ctl.rd_en) raddr = ctl.rd_addr;
    else if (ctl.latch && in_command == ppe_pkg::CMD_EMIT) raddr = next_slot_r;
    else if (ctl.latch) raddr = in_slot_index;
    else raddr = idx_r;
  end

  ppe_ram #(.Width(257), .Depth(ppe_pkg::PoolSize)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // stage 1: products
  logic signed [63:0] px_r, py_r, pz_r;
  logic [256:0] s1_r;
  logic signed [32:0] dts;
  assign dts = {2'b00, dt_r};
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      px_r <= 64'($signed(rdata[159:128])) * 64'(dts);
      py_r <= 64'($signed(rdata[127:96])) * 64'(dts);
      pz_r <= 64'($signed(rdata[95:64])) * 64'(dts);
      s1_r <= rdata;
    end
  end

  logic signed [31:0] life_old;
  logic was_act, live;
  assign life_old = s1_r[63:32];
  assign was_act = s1_r[256];
  assign live = was_act && (life_old > 0);
  always_comb begin
    upd_word = s1_r;
    if (live) begin
      upd_word[255:224] = ppe_pkg::sat_add(49'($signed(s1_r[255:224])) + 49'(px_r >>> 16));
      upd_word[223:192] = ppe_pkg::sat_add(49'($signed(s1_r[223:192])) + 49'(py_r >>> 16));
      upd_word[191:160] = ppe_pkg::sat_add(49'($signed(s1_r[191:160])) + 49'(pz_r >>> 16));
      upd_word[63:32]   = ppe_pkg::sat_add(49'(life_old) - 49'(dts));
      upd_word[31:0]    = s1_r[31:0] + rstep_r;
    end else begin
      upd_word[256] = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    next_slot_nxt = next_slot_r;
    if (ctl.emit_wr) begin
      if (!rdata[256]) cnt_nxt = cnt_r + 1'b1;
      next_slot_nxt = (next_slot_r == '0) ? W'(ppe_pkg::PoolSize - 1) : next_slot_r - 1'b1;
    end else if (ctl.upd_wr && was_act && !live) begin
      if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      next_slot_r <= W'(ppe_pkg::PoolSize - 1);
    end else begin
      cnt_r <= cnt_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  // slot reported by emit, held from the write cycle
  logic [W-1:0] emit_slot_r;
  always_ff @(posedge clk) if (ctl.emit_wr) emit_slot_r <= next_slot_r;

  logic rd_act;
  assign rd_act = rdata[256];
  always_comb begin
    out_valid = ctl.report;
    out_slot_out = '0;
    out_slot_active = 1'b0;
    out_x = '0; out_y = '0; out_z = '0; out_rotation = '0; out_life = '0;
    out_active_count = cnt_r;
    if (ctl.report) begin
      unique case (ppe_pkg::cmd_t'(cmd_r))
        ppe_pkg::CMD_EMIT: begin
          out_slot_out = emit_slot_r;
          out_slot_active = 1'b1;
        end
        ppe_pkg::CMD_READ: begin
          out_slot_out = idx_r;
          if (rd_act) begin
            out_slot_active = 1'b1;
            out_x = rdata[255:224];
            out_y = rdata[223:192];
            out_z = rdata[191:160];
            out_life = rdata[63:32];
            out_rotation = rdata[31:0];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/particle_pool_engine.sv
// top level of the particle pool engine
`timescale 1ns / 1ps
// particle pool engine: 1024 particles in Q16.16 fixed point
// command channel: a beat is taken when start is high and busy low;
//   in_command picks emit (0), tick (1), read (2) or no-op (3)
// result channel: one beat per command, out_valid high for one cycle,
//   the receiver cannot stall it
// emit and no-op pass the accept, command and done states, read adds a read wait state
//   and tick the slot sweep; the next beat can be taken the cycle after the result
// a tick sweeps the single particle memory one slot per cycle, read,
//   multiply and write back in a three stage pipeline; that memory port
//   sets the tick length
// one command is in flight at a time; busy is high through its result beat
// the active flag of each slot lives in the particle memory word
// reset clears the count and sets the emit pointer to the top slot, then a
//   pass clears every slot with busy held high
module particle_pool_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic [9:0]                in_slot_index,
  input  logic signed [31:0]        in_pos_x, in_pos_y, in_pos_z,
  input  logic signed [31:0]        in_vel_x, in_vel_y, in_vel_z,
  input  logic [30:0]               in_life_time,
  input  logic [30:0]               in_delta_time,
  output logic                      out_valid,
  output logic [9:0]                out_slot_out,
  output logic                      out_slot_active,
  output logic signed [31:0]        out_x, out_y, out_z,
  output logic [31:0]               out_rotation,
  output logic signed [31:0]        out_life,
  output logic [10:0]               out_active_count
);
  ppe_pkg::ctl_t ctl;
  ppe_pkg::sts_t sts;

  ppe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  ppe_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_command(in_command), .in_slot_index(in_slot_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_life_time(in_life_time), .in_delta_time(in_delta_time),
    .out_valid(out_valid), .out_slot_out(out_slot_out),
    .out_slot_active(out_slot_active), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_rotation(out_rotation), .out_life(out_life),
    .out_active_count(out_active_count)
  );
endmodule
